>>> sv/xorshift64_star_generator_macros.svh
// Assertion macros for the xorshift64* generator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef XORSHIFT64_STAR_GENERATOR_MACROS_SVH
`define XORSHIFT64_STAR_GENERATOR_MACROS_SVH

`ifndef SYNTH
`define XS64S_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define XS64S_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define XS64S_ASSERT_IMPL(label, clock, resetn, ante, cons)
`define XS64S_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif

`endif

>>> sv/xs64s_pkg.sv
// Shared types, constants and functions of the xorshift64* generator.
// No dependencies; imported by every module of the block.
package xs64s_pkg;

    localparam logic [63:0] XS_MULT        = 64'd2685821657736338717;
    localparam logic [31:0] XS_SEED_RESET  = 32'd1;
    localparam int          XS_QUEUE_DEPTH = 4;
    localparam logic [2:0]  XS_HASH_LAST   = 3'd6;
    localparam int          XS_DIV_STEPS   = 32;

    typedef enum logic [2:0] {
        XS_ACT_RESTART = 3'd0,
        XS_ACT_RAW     = 3'd1,
        XS_ACT_INT     = 3'd2,
        XS_ACT_FRAC    = 3'd3,
        XS_ACT_RANGE   = 3'd4
    } xs_action_t;

    typedef enum logic {
        XS_F_RUN,
        XS_F_HASH
    } xs_front_state_t;

    typedef enum logic [2:0] {
        XS_B_IDLE,
        XS_B_MUL,
        XS_B_PREP,
        XS_B_DIV,
        XS_B_FIX,
        XS_B_WRITE
    } xs_back_state_t;

    typedef struct packed {
        logic               draw;
        logic               ranged;
        logic [63:0]        state;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } xs_entry_t;

    function automatic logic [63:0] xs_hash_step(input logic [63:0] k, input logic [2:0] step);
        logic [63:0] r;
        case (step)
            3'd0:    r = (~k) + (k << 21);
            3'd1:    r = k ^ (k >> 24);
            3'd2:    r = k + (k << 3) + (k << 8);
            3'd3:    r = k ^ (k >> 14);
            3'd4:    r = k + (k << 2) + (k << 4);
            3'd5:    r = k ^ (k >> 28);
            default: r = k + (k << 31);
        endcase
        return r;
    endfunction

    function automatic logic [63:0] xs_wang_hash(input logic [63:0] k);
        logic [63:0] r;
        r = k;
        for (int i = 0; i <= int'(XS_HASH_LAST); i++)
        begin
            r = xs_hash_step(r, 3'(i));
        end
        return r;
    endfunction

    function automatic logic [63:0] xs_advance(input logic [63:0] s);
        logic [63:0] r;
        r = s ^ (s >> 12);
        r = r ^ (r << 25);
        r = r ^ (r >> 27);
        return r;
    endfunction

    localparam logic [63:0] XS_STATE_RESET = xs_wang_hash({32'd0, XS_SEED_RESET});

endpackage

>>> sv/xorshift64_star_generator.sv
// xorshift64* generator with a Wang-hashed 32-bit seed: a front end that takes
// items and advances the state, a back end that multiplies and reduces, and the
// queue between them; takes xs64s_pkg and the three sub-modules. The front end
// takes one item per cycle while the queue has room; a restart holds the input
// while the seed hash runs one step a cycle. The back end takes one queued item
// at a time: a draw goes through queue pop, three passes of the one 32x32
// multiplier, range setup and output load; a ranged draw with a valid range adds
// the 32 steps of the radix-2 remainder unit and a fixup step; a restart or an
// unused action code goes from queue pop to output load. The output register lets
// the back end start the next item while a result waits for m_tready. The seed
// register resets to 1 and only a restart loads it into the state.
module xorshift64_star_generator
    import xs64s_pkg::*;
#(
    parameter int QUEUE_DEPTH = XS_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,    // seed
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,     // range_low[31:0], range_high[63:32]
    input  logic [2:0]   s_tuser,     // action[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,     // raw_value[63:0], int_value[95:64], fraction[147:96]
    output logic         m_tuser      // status
);

    logic      push;
    xs_entry_t push_data;
    logic      full;
    logic      pop;
    xs_entry_t pop_data;
    logic      empty;

    xs64s_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    xs64s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    xs64s_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> sv/xs64s_front.sv
// Front end: seed register, input transfers, generator state and seed hashing.
// Depends on xs64s_pkg; feeds xs64s_queue.
module xs64s_front
    import xs64s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // range_low[31:0], range_high[63:32]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        push,
    output xs_entry_t   push_data,
    input  logic        full
);

    xs_front_state_t state_reg, state_next;
    logic [31:0]     seed_reg;
    logic [63:0]     gen_reg, gen_next;
    logic [2:0]      step_reg, step_next;
    logic            accept;
    xs_action_t      action;
    logic [63:0]     gen_adv;

    assign cfg_ready = 1'b1;
    assign action    = xs_action_t'(s_tuser);
    assign accept    = s_tvalid && s_tready;
    assign gen_adv   = xs_advance(gen_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            XS_F_RUN:
            begin
                if (accept && action == XS_ACT_RESTART)
                begin
                    state_next = XS_F_HASH;
                end
            end
            XS_F_HASH:
            begin
                if (step_reg == XS_HASH_LAST)
                begin
                    state_next = XS_F_RUN;
                end
            end
            default: state_next = XS_F_RUN;
        endcase
    end

    always_comb
    begin
        s_tready         = (state_reg == XS_F_RUN) && !full;
        push             = 1'b0;
        push_data.draw   = 1'b0;
        push_data.ranged = 1'b0;
        push_data.state  = gen_adv;
        push_data.lo     = s_tdata[31:0];
        push_data.hi     = s_tdata[63:32];
        gen_next         = gen_reg;
        step_next        = step_reg;
        case (state_reg)
            XS_F_RUN:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (action)
                        XS_ACT_RESTART:
                        begin
                            gen_next  = {32'd0, seed_reg};
                            step_next = 3'd0;
                        end
                        XS_ACT_RAW, XS_ACT_INT, XS_ACT_FRAC:
                        begin
                            push_data.draw = 1'b1;
                            gen_next       = gen_adv;
                        end
                        XS_ACT_RANGE:
                        begin
                            push_data.draw   = 1'b1;
                            push_data.ranged = 1'b1;
                            gen_next         = gen_adv;
                        end
                        default: ;
                    endcase
                end
            end
            XS_F_HASH:
            begin
                gen_next  = xs_hash_step(gen_reg, step_reg);
                step_next = (step_reg == XS_HASH_LAST) ? 3'd0 : step_reg + 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= XS_F_RUN;
            seed_reg  <= XS_SEED_RESET;
            gen_reg   <= XS_STATE_RESET;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= cfg_data;
            end
        end
    end

endmodule

>>> sv/xs64s_queue.sv
// Short queue of classified items between front end and back end.
// Depends on xs64s_pkg and the assertion macro header.
`include "xorshift64_star_generator_macros.svh"
module xs64s_queue
    import xs64s_pkg::*;
#(
    parameter int DEPTH = XS_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  xs_entry_t push_data,
    output logic      full,
    input  logic      pop,
    output xs_entry_t pop_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xs_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `XS64S_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full)
    `XS64S_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty)
    `XS64S_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, count_reg != '0)

endmodule

>>> sv/xs64s_back.sv
// Back end: scrambling multiply, ranged remainder and the output register.
// Depends on xs64s_pkg and the assertion macro header; drains xs64s_queue.
`include "xorshift64_star_generator_macros.svh"
module xs64s_back
    import xs64s_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         empty,
    input  xs_entry_t    pop_data,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // raw_value[63:0], int_value[95:64], fraction[147:96]
    output logic         m_tuser    // status
);

    localparam int DCNT_W = $clog2(XS_DIV_STEPS);

    xs_back_state_t    state_reg, state_next;
    xs_entry_t         ent_reg, ent_next;
    logic [1:0]        mstep_reg, mstep_next;
    logic [63:0]       acc_reg, acc_next;
    logic [31:0]       int_reg, int_next;
    logic              status_reg, status_next;
    logic [32:0]       div_reg, div_next;
    logic [33:0]       rem_reg, rem_next;
    logic [31:0]       quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [63:0]       out_raw_reg;
    logic [31:0]       out_int_reg;
    logic              out_status_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] product;
    logic [33:0] span;
    logic        span_ok;
    logic [31:0] mag;
    logic [33:0] div_ext;
    logic [33:0] trial;
    logic [31:0] rem32;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign span     = {{2{ent_reg.hi[31]}}, ent_reg.hi} - {{2{ent_reg.lo[31]}}, ent_reg.lo}
                      + 34'd1;
    assign span_ok  = !span[33] && (span != 34'd0);
    assign mag      = acc_reg[31] ? (~acc_reg[31:0] + 32'd1) : acc_reg[31:0];
    assign div_ext  = {1'b0, div_reg};
    assign trial    = {rem_reg[32:0], quo_reg[31]};
    assign rem32    = rem_reg[31:0];

    always_comb
    begin
        case (mstep_reg)
            2'd0:    begin mul_a = ent_reg.state[31:0];  mul_b = XS_MULT[31:0];  end
            2'd1:    begin mul_a = ent_reg.state[63:32]; mul_b = XS_MULT[31:0];  end
            default: begin mul_a = ent_reg.state[31:0];  mul_b = XS_MULT[63:32]; end
        endcase
        product = mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            XS_B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = pop_data.draw ? XS_B_MUL : XS_B_WRITE;
                end
            end
            XS_B_MUL:
            begin
                if (mstep_reg == 2'd2)
                begin
                    state_next = XS_B_PREP;
                end
            end
            XS_B_PREP:  state_next = (ent_reg.ranged && span_ok) ? XS_B_DIV : XS_B_WRITE;
            XS_B_DIV:
            begin
                if (dcnt_reg == DCNT_W'(XS_DIV_STEPS - 1))
                begin
                    state_next = XS_B_FIX;
                end
            end
            XS_B_FIX:   state_next = XS_B_WRITE;
            XS_B_WRITE:
            begin
                if (out_free)
                begin
                    state_next = XS_B_IDLE;
                end
            end
            default:    state_next = XS_B_IDLE;
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        ent_next      = ent_reg;
        mstep_next    = mstep_reg;
        acc_next      = acc_reg;
        int_next      = int_reg;
        status_next   = status_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        neg_next      = neg_reg;
        dcnt_next     = dcnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            XS_B_IDLE:
            begin
                pop         = !empty;
                ent_next    = pop_data;
                mstep_next  = 2'd0;
                acc_next    = 64'd0;
                int_next    = 32'd0;
                status_next = 1'b0;
            end
            XS_B_MUL:
            begin
                mstep_next = mstep_reg + 2'd1;
                if (mstep_reg == 2'd0)
                begin
                    acc_next = product;
                end
                else
                begin
                    acc_next = {acc_reg[63:32] + product[31:0], acc_reg[31:0]};
                end
            end
            XS_B_PREP:
            begin
                int_next = acc_reg[31:0];
                if (ent_reg.ranged)
                begin
                    if (span_ok)
                    begin
                        div_next  = span[32:0];
                        rem_next  = 34'd0;
                        quo_next  = mag;
                        neg_next  = acc_reg[31];
                        dcnt_next = '0;
                    end
                    else
                    begin
                        int_next    = 32'd0;
                        status_next = 1'b1;
                    end
                end
            end
            XS_B_DIV:
            begin
                rem_next  = (trial >= div_ext) ? trial - div_ext : trial;
                quo_next  = {quo_reg[30:0], 1'b0};
                dcnt_next = dcnt_reg + DCNT_W'(1);
            end
            XS_B_FIX:
            begin
                int_next = (neg_reg ? (~rem32 + 32'd1) : rem32) + ent_reg.lo;
            end
            XS_B_WRITE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        mstep_reg  <= mstep_next;
        acc_reg    <= acc_next;
        int_reg    <= int_next;
        status_reg <= status_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        dcnt_reg   <= dcnt_next;
        if (state_reg == XS_B_WRITE && out_free)
        begin
            out_raw_reg    <= acc_reg;
            out_int_reg    <= int_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= XS_B_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_raw_reg[63:12], out_int_reg, out_raw_reg};
    assign m_tuser  = out_status_reg;

    `XS64S_ASSERT_IMPL(a_rem_below_div, clk, rst_n, state_reg == XS_B_DIV, rem_reg < div_ext)
    `XS64S_ASSERT_IMPL(a_err_int_zero, clk, rst_n, m_tvalid_reg && out_status_reg,
        out_int_reg == 32'd0)
    `XS64S_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid_reg && !m_tready, m_tvalid_reg)

endmodule

>>> sim/xorshift64_star_generator_tb.sv
// Self-checking testbench for the xorshift64* generator: drives actions and seeds,
// predicts every result in a scoreboard class and compares each field on transfer.
// Depends on xs64s_pkg and the xorshift64_star_generator top level.
module xorshift64_star_generator_tb
    import xs64s_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int PHASE_ITEMS    = 216;
    localparam int PRESSURE_HOLD  = 400;

    typedef struct {
        bit [63:0] raw;
        bit [31:0] ival;
        bit [51:0] frac;
        bit        status;
    } draw_result_t;

    class draw_scoreboard;
        bit [31:0]    seed_reg;
        bit [63:0]    gen_state;
        draw_result_t expected_q[$];
        int           errors;

        function new();
            seed_reg  = 32'd1;
            gen_state = wang_hash64({32'd0, seed_reg});
            errors    = 0;
        endfunction

        function bit [63:0] wang_hash64(bit [63:0] k);
            k = ~k + (k << 21);
            k = k ^ (k >> 24);
            k = k * 64'd265;
            k = k ^ (k >> 14);
            k = k * 64'd21;
            k = k ^ (k >> 28);
            k = k + (k << 31);
            return k;
        endfunction

        function void set_seed(bit [31:0] value);
            seed_reg = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(bit [2:0] action, bit [31:0] lo, bit [31:0] hi);
            draw_result_t r;
            bit [63:0]    s;
            longint       lo_l;
            longint       hi_l;
            longint       span;
            longint       low_int;
            longint       ranged;
            r.raw    = '0;
            r.ival   = '0;
            r.frac   = '0;
            r.status = 1'b0;
            case (action)
                XS_ACT_RESTART:
                begin
                    gen_state = wang_hash64({32'd0, seed_reg});
                end
                XS_ACT_RAW, XS_ACT_INT, XS_ACT_FRAC, XS_ACT_RANGE:
                begin
                    s = gen_state;
                    s = s ^ (s >> 12);
                    s = s ^ (s << 25);
                    s = s ^ (s >> 27);
                    gen_state = s;
                    r.raw  = s * XS_MULT;
                    r.ival = r.raw[31:0];
                    r.frac = r.raw[63:12];
                    if (action == XS_ACT_RANGE)
                    begin
                        lo_l    = $signed(lo);
                        hi_l    = $signed(hi);
                        low_int = $signed(r.raw[31:0]);
                        span    = hi_l - lo_l + 1;
                        if (span <= 0)
                        begin
                            r.ival   = '0;
                            r.status = 1'b1;
                        end
                        else
                        begin
                            ranged = low_int % span + lo_l;
                            r.ival = ranged[31:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(bit [63:0] raw, bit [31:0] ival, bit [51:0] frac, bit status);
            draw_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual raw %h int %h frac %h st %b",
                         $time, raw, ival, frac, status);
                return;
            end
            e = expected_q.pop_front();
            compare_field("raw_value", e.raw, raw);
            compare_field("int_value", {32'd0, e.ival}, {32'd0, ival});
            compare_field("fraction", {12'd0, e.frac}, {12'd0, frac});
            compare_field("status", {63'd0, e.status}, {63'd0, status});
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic         m_tuser;

    draw_scoreboard sb;
    int             idle_pct;
    int             stall_pct;
    int             hold_cycles;
    int             cycle_count;

    xorshift64_star_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("xorshift64_star_generator_tb: done, errors");
        $finish;
    end

    // check each result transfer, then pick the next ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata[63:0], m_tdata[95:64], m_tdata[147:96], m_tuser);
            end
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_item(bit [2:0] action, bit [31:0] lo, bit [31:0] hi);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {hi, lo};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_input(action, lo, hi);
    endtask

    task automatic send_random_item();
        int        pick;
        bit [2:0]  action;
        bit [31:0] lo;
        bit [31:0] hi;
        pick = $urandom_range(99);
        lo   = $urandom;
        hi   = $urandom;
        if (pick < 5)
        begin
            action = XS_ACT_RESTART;
        end
        else if (pick < 9)
        begin
            action = 3'(5 + $urandom_range(2));
        end
        else
        begin
            action = 3'($urandom_range(4, 1));
        end
        if (action == XS_ACT_RANGE)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: hi = lo + $urandom_range(100);
                5:             hi = $urandom;
                6:             hi = lo;
                7:             hi = lo - 1;
                8:
                begin
                    lo = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    hi = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                default:
                begin
                    lo = -$urandom_range(1000);
                    hi = $urandom_range(1000);
                end
            endcase
        end
        send_item(action, lo, hi);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(bit [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.set_seed(value);
    endtask

    initial
    begin
        bit [31:0] phase_seed [8];
        sb          = new();
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        phase_seed  = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom,
                        $urandom, 32'h1, $urandom, $urandom};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state first, then bounds at the edges of the range
        send_item(XS_ACT_RAW, $urandom, $urandom);
        send_item(XS_ACT_INT, $urandom, $urandom);
        send_item(XS_ACT_FRAC, $urandom, $urandom);
        send_item(XS_ACT_RANGE, 32'd0, 32'd9);
        send_item(XS_ACT_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(XS_ACT_RANGE, 32'd5, 32'd5);
        send_item(XS_ACT_RANGE, 32'h8000_0000, 32'h8000_0000);
        send_item(XS_ACT_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(XS_ACT_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(XS_ACT_RANGE, 32'd10, 32'd9);
        send_item(XS_ACT_RANGE, -32'd100, -32'd1);
        send_item(XS_ACT_RANGE, -32'd7, 32'd7);
        send_item(XS_ACT_RANGE, 32'd0, 32'h7FFF_FFFF);
        send_item(XS_ACT_RANGE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(3'd5, $urandom, $urandom);
        send_item(3'd6, $urandom, $urandom);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(XS_ACT_RAW, 32'h0, 32'h0);
        send_item(XS_ACT_RESTART, $urandom, $urandom);
        send_item(XS_ACT_RAW, $urandom, $urandom);
        send_item(XS_ACT_RESTART, $urandom, $urandom);
        send_item(XS_ACT_RANGE, 32'd1, 32'd1000);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_seed(phase_seed[p]);
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 77; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            if (p == 4)
            begin
                hold_cycles = PRESSURE_HOLD;
            end
            // phase 2 keeps the old state to show a seed write alone does not reload it
            if (p != 2)
            begin
                send_item(XS_ACT_RESTART, $urandom, $urandom);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random_item();
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("xorshift64_star_generator_tb: done, clean");
        end
        else
        begin
            $display("xorshift64_star_generator_tb: done, errors");
        end
        $finish;
    end

endmodule
